FILE: rtl/cosdir_pkg.sv
`default_nettype none
package cosdir_pkg;

    localparam int FRAC_BITS = 14;
    localparam int VEC_W     = 16;
    localparam int SMPZ_W    = 15;
    localparam int PDF_W     = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;

    // normalizer input: signed, wide enough for the weighted sum
    localparam int NW    = 34;
    localparam int MAG_W = NW - 1;
    localparam int POS_W = 6;
    localparam int TOP_BIT = 29;
    localparam int SH_W  = TOP_BIT + 1;
    localparam int SQ_W  = 2 * SH_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int ROOT_W = SUM_W + 1;
    localparam int ROOT_STEPS = SUM_W / 2;
    // length reaches sqrt(3) * 2^30, so it needs one bit past SH_W
    localparam int LEN_W = ROOT_STEPS;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int DIV_STEPS = Q_W;
    localparam int REM_W = SH_W + FRAC_BITS + 1;
    localparam int NORM_STAGES = 5 + ROOT_STEPS + 1 + DIV_STEPS;

    localparam int RS_IN_W  = 36;
    localparam int RS_OUT_W = 22;

    localparam int UP_X = ((34 << FRAC_BITS) + 5000) / 10000;
    localparam int UP_Y = 1 << FRAC_BITS;
    localparam int UP_Z = ((71 << FRAC_BITS) + 5000) / 10000;
    localparam int INV_PI_W = 29;
    localparam logic [INV_PI_W-1:0] INV_PI_Q30 = INV_PI_W'(341782638);

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 112;

    typedef logic signed [NW-1:0]    wide_t;
    typedef logic signed [VEC_W-1:0] comp_t;

    localparam comp_t UP_X_Q = comp_t'(UP_X);
    localparam comp_t UP_Y_Q = comp_t'(UP_Y);
    localparam comp_t UP_Z_Q = comp_t'(UP_Z);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN  = 8'd0,
        REG_RED   = 8'd1,
        REG_GREEN = 8'd2,
        REG_BLUE  = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        comp_t              nx;
        comp_t              ny;
        comp_t              nz;
        comp_t              sx;
        comp_t              sy;
        logic [SMPZ_W-1:0]  sz;
        logic               degen;
    } side_t;

    // Q(2F) -> Q(F), round half away from zero
    function automatic logic signed [RS_OUT_W-1:0] rescale(input logic signed [RS_IN_W-1:0] x);
        logic [RS_IN_W-1:0]  m;
        logic [RS_OUT_W-1:0] r;
        m = x[RS_IN_W-1] ? RS_IN_W'(-x) : RS_IN_W'(x);
        r = RS_OUT_W'((m + RS_IN_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        return x[RS_IN_W-1] ? -$signed(r) : $signed(r);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cosine_hemisphere_direction_core.sv
// Pipeline from input item accept to result valid: cross product,
// two 52-stage normalizers with square root and divide pipelines, basis and pdf stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: rst_n clears all valid bits and sets the four configuration registers to zero.
`default_nettype none
module cosine_hemisphere_direction_core
    import cosdir_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // normal_x, normal_y, normal_z, sample_x, sample_y, sample_z, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // dir_x, dir_y, dir_z, pdf_out, refl_red, refl_green, refl_blue, zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // degenerate
    output logic                       m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    logic adv;

    logic [CFG_W-1:0] gain_reg, red_reg, green_reg, blue_reg;
    logic [CFG_W-1:0] refl_r, refl_g, refl_b;

    comp_t n [3];
    side_t in_side;
    logic  x_vld_reg;
    wide_t x_c_reg [3];
    side_t x_side_reg;

    logic  n1_valid, n1_zero;
    comp_t n1_q [3];
    side_t n1_side;

    logic  b_valid;
    wide_t b_w [3];
    side_t b_side;

    logic  n2_valid, n2_zero;
    comp_t n2_q [3];
    side_t n2_side;

    logic             o_valid, o_degen;
    comp_t            o_dir [3];
    logic [PDF_W-1:0] o_pdf;

    assign adv       = !o_valid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN:  gain_reg  <= cfg_data;
                REG_RED:   red_reg   <= cfg_data;
                REG_GREEN: green_reg <= cfg_data;
                REG_BLUE:  blue_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        in_side.nx    = s_tdata[15:0];
        in_side.ny    = s_tdata[31:16];
        in_side.nz    = s_tdata[47:32];
        in_side.sx    = s_tdata[63:48];
        in_side.sy    = s_tdata[79:64];
        in_side.sz    = s_tdata[94:80];
        in_side.degen = 1'b0;
        n[0] = in_side.nx;
        n[1] = in_side.ny;
        n[2] = in_side.nz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            x_vld_reg <= s_tvalid;
        end
    end

    // up x n, exact in Q28
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_side_reg <= in_side;
            x_c_reg[0] <= UP_Y_Q * n[2] - UP_Z_Q * n[1];
            x_c_reg[1] <= UP_Z_Q * n[0] - UP_X_Q * n[2];
            x_c_reg[2] <= UP_X_Q * n[1] - UP_Y_Q * n[0];
        end
    end

    cosdir_norm u_norm_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (x_vld_reg),
        .in_c     (x_c_reg),
        .in_side  (x_side_reg),
        .out_valid(n1_valid),
        .out_q    (n1_q),
        .out_zero (n1_zero),
        .out_side (n1_side)
    );

    cosdir_basis u_basis (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (n1_valid),
        .in_v     (n1_q),
        .in_zero  (n1_zero),
        .in_side  (n1_side),
        .out_valid(b_valid),
        .out_w    (b_w),
        .out_side (b_side)
    );

    cosdir_norm u_norm_d (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (b_valid),
        .in_c     (b_w),
        .in_side  (b_side),
        .out_valid(n2_valid),
        .out_q    (n2_q),
        .out_zero (n2_zero),
        .out_side (n2_side)
    );

    cosdir_shade u_shade (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (n2_valid),
        .in_d     (n2_q),
        .in_zero  (n2_zero),
        .in_side  (n2_side),
        .out_valid(o_valid),
        .out_dir  (o_dir),
        .out_pdf  (o_pdf),
        .out_degen(o_degen)
    );

    cosdir_refl u_refl_r (.clk(clk), .gain(gain_reg), .color(red_reg),   .refl(refl_r));
    cosdir_refl u_refl_g (.clk(clk), .gain(gain_reg), .color(green_reg), .refl(refl_g));
    cosdir_refl u_refl_b (.clk(clk), .gain(gain_reg), .color(blue_reg),  .refl(refl_b));

    assign m_tvalid = o_valid;
    assign m_tuser  = o_degen;
    assign m_tdata  = {1'b0, refl_b, refl_g, refl_r, o_pdf, o_dir[2], o_dir[1], o_dir[0]};

endmodule
`default_nettype wire

FILE: rtl/cosdir_norm.sv
`default_nettype none
module cosdir_norm
    import cosdir_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire wide_t in_c [3],
    input  wire side_t in_side,
    output logic       out_valid,
    output comp_t      out_q [3],
    output logic       out_zero,
    output side_t      out_side
);

    typedef struct packed {
        side_t      side;
        logic [2:0] neg;
        logic       zero;
    } tag_t;

    logic vld_reg [NORM_STAGES];
    tag_t tag_reg [NORM_STAGES];
    tag_t tag_next;

    logic [MAG_W-1:0] a_mag_reg [3];
    logic [MAG_W-1:0] a_max_reg;
    logic [MAG_W-1:0] a_mag_next [3];
    logic [MAG_W-1:0] a_max_next;

    logic [MAG_W-1:0] b_mag_reg [3];
    logic [POS_W-1:0] b_pos_reg;
    logic [POS_W-1:0] b_pos_next;

    logic [SH_W-1:0]  c_m_reg [3];
    logic [SH_W-1:0]  c_m_next [3];

    logic [SH_W-1:0]  d_m_reg [3];
    logic [SQ_W-1:0]  d_sq_reg [3];

    logic [SUM_W-1:0]  rt_x_reg [ROOT_STEPS+1];
    logic [ROOT_W-1:0] rt_r_reg [ROOT_STEPS+1];
    logic [SH_W-1:0]   rt_m_reg [ROOT_STEPS+1][3];

    logic [REM_W-1:0]  dv_rem_reg [DIV_STEPS+1][3];
    logic [LEN_W-1:0]  dv_len_reg [DIV_STEPS+1];
    logic [Q_W-1:0]    dv_q_reg   [DIV_STEPS+1][3];

    always_comb
    begin
        tag_next.side = in_side;
        tag_next.zero = (in_c[0] == '0) && (in_c[1] == '0) && (in_c[2] == '0);
        for (int i = 0; i < 3; i++)
        begin
            tag_next.neg[i] = in_c[i][NW-1];
            a_mag_next[i]   = in_c[i][NW-1] ? MAG_W'(-in_c[i]) : MAG_W'(in_c[i]);
        end
        a_max_next = a_mag_next[0];
        if (a_mag_next[1] > a_max_next)
        begin
            a_max_next = a_mag_next[1];
        end
        if (a_mag_next[2] > a_max_next)
        begin
            a_max_next = a_mag_next[2];
        end
    end

    // leading one of the largest magnitude
    always_comb
    begin
        b_pos_next = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (a_max_reg[b])
            begin
                b_pos_next = POS_W'(b);
            end
        end
    end

    // bring the largest magnitude into [2^29, 2^30); right shifts truncate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b_pos_reg > POS_W'(TOP_BIT))
            begin
                c_m_next[i] = SH_W'(b_mag_reg[i] >> (b_pos_reg - POS_W'(TOP_BIT)));
            end
            else
            begin
                c_m_next[i] = SH_W'(b_mag_reg[i] << (POS_W'(TOP_BIT) - b_pos_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NORM_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NORM_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tag_next;
            for (int k = 1; k < NORM_STAGES; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
            a_max_reg <= a_max_next;
            b_pos_reg <= b_pos_next;
            for (int i = 0; i < 3; i++)
            begin
                a_mag_reg[i] <= a_mag_next[i];
                b_mag_reg[i] <= a_mag_reg[i];
                c_m_reg[i]   <= c_m_next[i];
                d_m_reg[i]   <= c_m_reg[i];
                d_sq_reg[i]  <= c_m_reg[i] * c_m_reg[i];
                rt_m_reg[0][i] <= d_m_reg[i];
            end
            rt_x_reg[0] <= SUM_W'(d_sq_reg[0]) + SUM_W'(d_sq_reg[1]) + SUM_W'(d_sq_reg[2]);
            rt_r_reg[0] <= '0;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - k));
        logic [ROOT_W-1:0] trial;
        logic              ge;

        assign trial = rt_r_reg[k] + BIT;
        assign ge    = ROOT_W'(rt_x_reg[k]) >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_x_reg[k+1] <= ge ? rt_x_reg[k] - SUM_W'(trial) : rt_x_reg[k];
                rt_r_reg[k+1] <= ge ? (rt_r_reg[k] >> 1) + BIT : rt_r_reg[k] >> 1;
                for (int i = 0; i < 3; i++)
                begin
                    rt_m_reg[k+1][i] <= rt_m_reg[k][i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_len_reg[0] <= LEN_W'(rt_r_reg[ROOT_STEPS]);
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= (REM_W'(rt_m_reg[ROOT_STEPS][i]) << FRAC_BITS)
                                  + REM_W'(rt_r_reg[ROOT_STEPS][LEN_W-1:1]);
                dv_q_reg[0][i]   <= '0;
            end
        end
    end

    // restoring division by the length, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int B = DIV_STEPS - 1 - j;
        logic [REM_W-1:0] trial;

        assign trial = REM_W'(dv_len_reg[j]) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_len_reg[j+1] <= dv_len_reg[j];
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_rem_reg[j][i] >= trial)
                    begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i] - trial;
                        dv_q_reg[j+1][i]   <= dv_q_reg[j][i] | (Q_W'(1) << B);
                    end
                    else
                    begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i];
                        dv_q_reg[j+1][i]   <= dv_q_reg[j][i];
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid = vld_reg[NORM_STAGES-1];
        out_zero  = tag_reg[NORM_STAGES-1].zero;
        out_side  = tag_reg[NORM_STAGES-1].side;
        for (int i = 0; i < 3; i++)
        begin
            if (tag_reg[NORM_STAGES-1].neg[i])
            begin
                out_q[i] = -$signed(VEC_W'(dv_q_reg[DIV_STEPS][i]));
            end
            else
            begin
                out_q[i] = $signed(VEC_W'(dv_q_reg[DIV_STEPS][i]));
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cosdir_basis.sv
`default_nettype none
module cosdir_basis
    import cosdir_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire comp_t in_v [3],
    input  wire logic  in_zero,
    input  wire side_t in_side,
    output logic       out_valid,
    output wide_t      out_w [3],
    output side_t      out_side
);

    localparam int UC_W = 33;
    localparam int U_W  = 18;

    logic  vld_reg [4];
    side_t side_reg [4];
    side_t side_next;

    comp_t n [3];
    comp_t n1 [3];
    comp_t n2 [3];

    logic signed [UC_W-1:0] uc_reg [3];
    comp_t                  v1_reg [3];
    logic signed [U_W-1:0]  u_reg [3];
    comp_t                  v2_reg [3];
    wide_t                  pu_reg [3];
    wide_t                  pv_reg [3];
    wide_t                  pn_reg [3];
    wide_t                  w_reg [3];
    logic signed [VEC_W-1:0] szs;

    always_comb
    begin
        side_next       = in_side;
        side_next.degen = in_zero;
        n[0]  = in_side.nx;
        n[1]  = in_side.ny;
        n[2]  = in_side.nz;
        n1[0] = side_reg[0].nx;
        n1[1] = side_reg[0].ny;
        n1[2] = side_reg[0].nz;
        n2[0] = side_reg[1].nx;
        n2[1] = side_reg[1].ny;
        n2[2] = side_reg[1].nz;
        szs   = $signed({1'b0, side_reg[1].sz});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < 4; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < 4; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            // u = v x n, exact in Q28
            uc_reg[0] <= in_v[1] * n[2] - in_v[2] * n[1];
            uc_reg[1] <= in_v[2] * n[0] - in_v[0] * n[2];
            uc_reg[2] <= in_v[0] * n[1] - in_v[1] * n[0];
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i] <= in_v[i];
                u_reg[i]  <= U_W'(rescale(RS_IN_W'(uc_reg[i])));
                v2_reg[i] <= v1_reg[i];
                pu_reg[i] <= side_reg[1].sx * u_reg[i];
                pv_reg[i] <= side_reg[1].sy * v2_reg[i];
                pn_reg[i] <= szs * n2[i];
                w_reg[i]  <= pu_reg[i] + pv_reg[i] + pn_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[3];
    assign out_side  = side_reg[3];
    assign out_w     = w_reg;

endmodule
`default_nettype wire

FILE: rtl/cosdir_shade.sv
`default_nettype none
module cosdir_shade
    import cosdir_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire comp_t in_d [3],
    input  wire logic  in_zero,
    input  wire side_t in_side,
    output logic       out_valid,
    output comp_t      out_dir [3],
    output logic [PDF_W-1:0] out_pdf,
    output logic       out_degen
);

    localparam int PR_W = 2 * VEC_W;
    localparam int DQ_W = 19;
    localparam int PP_W = DQ_W + INV_PI_W;
    localparam int DM_W = PP_W - 30;

    logic  vld_reg [5];
    logic  dg_reg [5];
    comp_t dir_reg [5][3];
    comp_t n [3];
    comp_t dsel [3];

    logic signed [PR_W-1:0]     pr_reg [3];
    wide_t                      dot_reg;
    logic signed [RS_OUT_W-1:0] dq;
    logic [DQ_W-1:0]            dq_reg;
    logic [PP_W-1:0]            pp_reg;
    logic [DM_W-1:0]            dm;
    logic [PDF_W-1:0]           pdf_reg;

    always_comb
    begin
        n[0] = in_side.nx;
        n[1] = in_side.ny;
        n[2] = in_side.nz;
        for (int i = 0; i < 3; i++)
        begin
            priority if (in_side.degen)
            begin
                dsel[i] = n[i];
            end
            else if (in_zero)
            begin
                dsel[i] = '0;
            end
            else
            begin
                dsel[i] = in_d[i];
            end
        end
        dq = rescale(RS_IN_W'(dot_reg));
        dm = DM_W'((pp_reg + PP_W'(1 << 29)) >> 30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 5; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < 5; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dg_reg[0] <= in_side.degen;
            for (int i = 0; i < 3; i++)
            begin
                dir_reg[0][i] <= dsel[i];
                pr_reg[i]     <= n[i] * dsel[i];
            end
            for (int k = 1; k < 5; k++)
            begin
                dg_reg[k]  <= dg_reg[k-1];
                dir_reg[k] <= dir_reg[k-1];
            end
            dot_reg <= wide_t'(pr_reg[0]) + wide_t'(pr_reg[1]) + wide_t'(pr_reg[2]);
            // clamp at zero before scaling by 1/pi
            dq_reg  <= (dq > 0) ? DQ_W'(dq) : '0;
            pp_reg  <= dq_reg * INV_PI_Q30;
            pdf_reg <= (dm > DM_W'({PDF_W{1'b1}})) ? {PDF_W{1'b1}} : PDF_W'(dm);
        end
    end

    assign out_valid = vld_reg[4];
    assign out_degen = dg_reg[4];
    assign out_dir   = dir_reg[4];
    assign out_pdf   = pdf_reg;

endmodule
`default_nettype wire

FILE: rtl/cosdir_refl.sv
`default_nettype none
module cosdir_refl
    import cosdir_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [CFG_W-1:0] gain,
    input  wire logic [CFG_W-1:0] color,
    output logic [CFG_W-1:0]      refl
);

    localparam int GC_W = 2 * CFG_W;
    localparam int P_W  = GC_W + INV_PI_W;
    localparam int SH   = FRAC_BITS + 30;
    localparam int R_W  = P_W - SH;

    logic [GC_W-1:0] gc_reg;
    logic [P_W-1:0]  p_reg;
    logic [R_W-1:0]  r;
    logic [CFG_W-1:0] refl_reg;

    assign r = R_W'((p_reg + P_W'(64'd1 << (SH - 1))) >> SH);

    // user must keep registers static while items flow; not enforced
    always_ff @(posedge clk)
    begin
        gc_reg   <= gain * color;
        p_reg    <= gc_reg * INV_PI_Q30;
        refl_reg <= (r > R_W'({CFG_W{1'b1}})) ? {CFG_W{1'b1}} : CFG_W'(r);
    end

    assign refl = refl_reg;

endmodule
`default_nettype wire

FILE: rtl/cosdir_checker.sv
`default_nettype none
module cosdir_checker
    import cosdir_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tuser
);

    // input side holds exactly when a result is stuck
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    a_zero_dir_pdf: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && (m_tdata[47:0] == 48'd0) |-> (m_tdata[62:48] == 15'd0))
        else $error("zero direction with nonzero pdf");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            (m_tdata[15] ? (m_tdata[15:0] >= 16'hC000) : (m_tdata[15:0] <= 16'h4000)) &&
            (m_tdata[31] ? (m_tdata[31:16] >= 16'hC000) : (m_tdata[31:16] <= 16'h4000)) &&
            (m_tdata[47] ? (m_tdata[47:32] >= 16'hC000) : (m_tdata[47:32] <= 16'h4000)))
        else $error("normalized direction component beyond one");

endmodule

bind cosine_hemisphere_direction_core cosdir_checker u_cosdir_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
